### design/servo_command_frame_receiver_core_assert.svh
// Assertion macros for the servo command frame receiver.
`ifndef SERVO_COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SERVO_COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// implication checked on every rising clk edge outside reset
`define SCFR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// condition that never holds outside reset
`define SCFR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define SCFR_ASSERT_IMPL(label, ante, cons, msg)
`define SCFR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

### design/scfr_pkg.sv
// Shared types and constants of the servo command frame receiver.
package scfr_pkg;

	localparam int FRAME_LENGTH_DEF = 14;
	localparam int SERVO_COUNT      = 6;
	localparam int CKS_INDEX        = 9;
	localparam int SWITCH_INDEX     = 7;

	localparam logic [15:0] MIN_PULSE_RESET = 16'd20400;
	localparam logic [7:0]  POS_LIMIT       = 8'd157;

	localparam logic [7:0] CHAR_START  = 8'h43; // 'C'
	localparam logic [7:0] CHAR_E      = 8'h45; // 'E'
	localparam logic [7:0] CHAR_N      = 8'h4E; // 'N'
	localparam logic [7:0] CHAR_D      = 8'h44; // 'D'
	localparam logic [7:0] CHAR_RESYNC = 8'hFF;

	localparam logic [7:0] REPLY_NONE = 8'h00;
	localparam logic [7:0] REPLY_GOOD = 8'h47; // 'G'
	localparam logic [7:0] REPLY_CKS  = 8'h6B; // 'k'
	localparam logic [7:0] REPLY_SYNC = 8'h73; // 's'

	// per-byte result before the servo snapshot is attached
	typedef struct packed {
		logic [7:0] echo;
		logic       reply_valid;
		logic [7:0] reply;
		logic       in_sync;
	} res_t;

	// compare value for one channel: min_pulse - min(pos,157)*8, wraps at 16 bits
	function automatic logic [15:0] servo_value(input logic [15:0] min_pulse,
		input logic [7:0] pos);
		logic [7:0] p;
		p = (pos > POS_LIMIT) ? POS_LIMIT : pos;
		return min_pulse - {5'd0, p, 3'd0};
	endfunction

endpackage

### design/servo_command_frame_receiver_core.sv
// Servo command frame receiver: byte echo, frame check and servo compare registers.
//
// Input: one received byte per word on in_valid/in_ready (rx_byte).
// Output: exactly one word per input byte on out_valid/out_ready, carrying the
//   echoed byte, the frame verdict ('G', 'k', 's', or 0 with reply_valid low),
//   the six servo compare values, both switch bits and the sync flag, all as
//   they stand after that byte.
// Config: cfg_we/cfg_wdata write min_pulse; it is used by the next
//   good frame. Write only while no word is in flight.
// Results: each result passes the result stage and the output register; the byte
//   that completes a good frame is held in the result stage until the sweep ends.
// Throughput: one byte per cycle while out_ready is high and no sweep runs. A byte
//   that completes a good frame starts a sweep: bytes 1..6 are read back from the
//   frame RAM through its one read port (six reads, registered read data), one
//   servo register per cycle, and in_ready stays low meanwhile.
// Stalls: a result stage sits between input and output register, so one more
//   byte is taken while the output waits; after that in_ready follows out_ready.
// Reset: in sync, byte count zero, E/N/D latches clear, servos and min_pulse at
//   20400, switches low. The frame RAM is not cleared: every byte that a verdict
//   uses is written earlier in the same frame.
`include "servo_command_frame_receiver_core_assert.svh"

module servo_command_frame_receiver_core #(
	parameter int FRAME_LENGTH = scfr_pkg::FRAME_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  echo_byte,
	output logic        reply_valid,
	output logic [7:0]  reply_byte,
	output logic [15:0] servo_one,
	output logic [15:0] servo_two,
	output logic [15:0] servo_three,
	output logic [15:0] servo_four,
	output logic [15:0] servo_five,
	output logic [15:0] servo_six,
	output logic        switch_low,
	output logic        switch_high,
	output logic        in_sync
);

	localparam int CNT_W = $clog2(FRAME_LENGTH);
	localparam int SC    = scfr_pkg::SERVO_COUNT;
	localparam int SL_W  = $clog2(SC);
	localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(FRAME_LENGTH - 1);
	localparam logic [CNT_W-1:0] CNT_CKS    = CNT_W'(scfr_pkg::CKS_INDEX);
	localparam logic [CNT_W-1:0] CNT_SWITCH = CNT_W'(scfr_pkg::SWITCH_INDEX);
	localparam logic [CNT_W-1:0] CNT_FIRST  = CNT_W'(1);
	localparam logic [SL_W-1:0]  SLOT_LAST  = SL_W'(SC - 1);

	// control state
	logic [15:0]      min_pulse_q;
	logic [CNT_W-1:0] cnt_q, nxt_cnt;
	logic             sync_q, nxt_sync;
	logic             seen_e_q, seen_n_q, seen_d_q;
	logic             nxt_e, nxt_n, nxt_d;
	logic [15:0]      servo_q [SC];
	logic [1:0]       switch_q;

	// running frame checks
	logic             b0_ok_q;
	logic [7:0]       xor_q;
	logic             cks_ok_q;
	logic [1:0]       sw_cand_q;

	// servo update sweep
	logic             busy_q;
	logic [SL_W-1:0]  rd_idx_q;
	logic             rd_done_q;
	logic             rd_vld_q;
	logic [SL_W-1:0]  rd_slot_q;
	logic             ram_re;
	logic [7:0]       ram_rdata;
	logic [CNT_W-1:0] ram_raddr;

	// pipeline
	scfr_pkg::res_t   res_s1, res_new;
	logic             res_valid_s1;
	logic             out_valid_q;
	scfr_pkg::res_t   out_res_q;
	logic [15:0]      out_servo_q [SC];
	logic [1:0]       out_switch_q;

	logic             acc, move, ram_we, start_sweep, cks_ok_now;
	logic [7:0]       verdict;

	assign move     = res_valid_s1 && !busy_q && (!out_valid_q || out_ready);
	assign in_ready = !busy_q && (!res_valid_s1 || move);
	assign acc      = in_valid && in_ready;

	assign cks_ok_now = (cnt_q == CNT_CKS) ? (xor_q == rx_byte) : cks_ok_q;

	// next control state for the accepted byte
	always_comb begin
		nxt_cnt     = cnt_q;
		nxt_sync    = sync_q;
		nxt_e       = seen_e_q;
		nxt_n       = seen_n_q;
		nxt_d       = seen_d_q;
		ram_we      = 1'b0;
		start_sweep = 1'b0;
		verdict     = scfr_pkg::REPLY_NONE;
		if (acc) begin
			if (sync_q) begin
				ram_we = 1'b1;
				if (cnt_q == CNT_LAST) begin
					nxt_cnt = '0;
					if (!b0_ok_q) begin
						verdict  = scfr_pkg::REPLY_SYNC;
						nxt_sync = 1'b0;
					end else begin
						nxt_e = 1'b0;
						nxt_n = 1'b0;
						nxt_d = 1'b0;
						if (cks_ok_now) begin
							verdict     = scfr_pkg::REPLY_GOOD;
							start_sweep = 1'b1;
						end else begin
							verdict = scfr_pkg::REPLY_CKS;
						end
					end
				end else begin
					nxt_cnt = cnt_q + CNT_FIRST;
				end
			end else if (rx_byte == scfr_pkg::CHAR_E || seen_e_q) begin
				// latches chain on the same byte and hold once set
				nxt_e = 1'b1;
				if (rx_byte == scfr_pkg::CHAR_N || seen_n_q) begin
					nxt_n = 1'b1;
					if (rx_byte == scfr_pkg::CHAR_D || seen_d_q) begin
						nxt_d = 1'b1;
						if (rx_byte == scfr_pkg::CHAR_RESYNC) begin
							nxt_cnt  = '0;
							nxt_sync = 1'b1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		res_new.echo        = rx_byte;
		res_new.reply_valid = (verdict != scfr_pkg::REPLY_NONE);
		res_new.reply       = verdict;
		res_new.in_sync     = nxt_sync;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= scfr_pkg::MIN_PULSE_RESET;
			cnt_q       <= '0;
			sync_q      <= 1'b1;
			seen_e_q    <= 1'b0;
			seen_n_q    <= 1'b0;
			seen_d_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_pulse_q <= cfg_wdata;
			end
			cnt_q    <= nxt_cnt;
			sync_q   <= nxt_sync;
			seen_e_q <= nxt_e;
			seen_n_q <= nxt_n;
			seen_d_q <= nxt_d;
		end
	end

	// per-frame checks built up as the bytes go by
	always_ff @(posedge clk) begin
		if (acc && sync_q) begin
			if (cnt_q == '0) begin
				b0_ok_q <= (rx_byte == scfr_pkg::CHAR_START);
			end
			if (cnt_q == CNT_FIRST) begin
				xor_q <= rx_byte;
			end else if (cnt_q < CNT_CKS) begin
				xor_q <= xor_q ^ rx_byte;
			end
			if (cnt_q == CNT_CKS) begin
				cks_ok_q <= (xor_q == rx_byte);
			end
			if (cnt_q == CNT_SWITCH) begin
				sw_cand_q <= rx_byte[7:6];
			end
		end
	end

	// frame bytes; bytes 1..6 are read back after a good frame
	assign ram_re    = busy_q && !rd_done_q;
	assign ram_raddr = CNT_W'(rd_idx_q) + CNT_FIRST;

	scfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_LENGTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
			rd_vld_q  <= 1'b0;
			rd_slot_q <= '0;
			switch_q  <= 2'b00;
			for (int i = 0; i < SC; i++) begin
				servo_q[i] <= scfr_pkg::MIN_PULSE_RESET;
			end
		end else begin
			rd_vld_q  <= ram_re;
			rd_slot_q <= rd_idx_q;
			if (start_sweep) begin
				busy_q    <= 1'b1;
				rd_idx_q  <= '0;
				rd_done_q <= 1'b0;
			end else if (ram_re) begin
				rd_idx_q <= rd_idx_q + SL_W'(1);
				if (rd_idx_q == SLOT_LAST) begin
					rd_done_q <= 1'b1;
				end
			end
			if (rd_vld_q) begin
				servo_q[rd_slot_q] <= scfr_pkg::servo_value(min_pulse_q, ram_rdata);
				if (rd_slot_q == SLOT_LAST) begin
					busy_q   <= 1'b0;
					switch_q <= sw_cand_q;
				end
			end
		end
	end

	// result stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (acc) begin
				res_valid_s1 <= 1'b1;
			end else if (move) begin
				res_valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_new;
		end
		if (move) begin
			out_res_q    <= res_s1;
			out_switch_q <= switch_q;
			for (int i = 0; i < SC; i++) begin
				out_servo_q[i] <= servo_q[i];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign echo_byte   = out_res_q.echo;
	assign reply_valid = out_res_q.reply_valid;
	assign reply_byte  = out_res_q.reply;
	assign in_sync     = out_res_q.in_sync;
	assign servo_one   = out_servo_q[0];
	assign servo_two   = out_servo_q[1];
	assign servo_three = out_servo_q[2];
	assign servo_four  = out_servo_q[3];
	assign servo_five  = out_servo_q[4];
	assign servo_six   = out_servo_q[5];
	assign switch_low  = out_switch_q[0];
	assign switch_high = out_switch_q[1];

	// the sweep owns the RAM; no frame byte may land while it reads
	`SCFR_ASSERT_NEVER(a_no_write_in_sweep, busy_q && ram_we, "frame RAM written during servo sweep")
	// the byte count never runs past the frame
	`SCFR_ASSERT_IMPL(a_cnt_range, sync_q, cnt_q <= CNT_LAST, "byte count beyond frame length")
	// a sweep only runs for a held good verdict
	`SCFR_ASSERT_IMPL(a_sweep_good, busy_q, res_valid_s1 && res_s1.reply == scfr_pkg::REPLY_GOOD, "servo sweep without good frame")

endmodule

### design/scfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
